// ===== hdl/jcsm_pkg.sv =====
package jcsm_pkg;

  localparam int ELEM_W = 32;
  localparam logic [7:0] ROOT_MARK = 8'hFF;

  localparam logic [1:0] OP_LOCAL   = 2'd0;
  localparam logic [1:0] OP_INVBIND = 2'd1;
  localparam logic [1:0] OP_BIND    = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  typedef logic [3:0][ELEM_W-1:0]  row_t;
  typedef logic [15:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic start;
    logic mem_is_a;
  } eng_req_t;

  typedef struct packed {
    logic       wr_valid;
    logic [3:0] wr_idx;
    logic       done;
  } eng_rsp_t;

endpackage

// ===== hdl/jcsm_ram.sv =====
module jcsm_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/jcsm_matmul.sv =====
module jcsm_matmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  jcsm_pkg::eng_req_t           req,
  input  jcsm_pkg::mat_t               opm,
  input  jcsm_pkg::row_t               rd_data,
  output logic [1:0]                   rd_row,
  output jcsm_pkg::eng_rsp_t           rsp,
  output logic [jcsm_pkg::ELEM_W-1:0]  wr_data
);
  import jcsm_pkg::*;

  localparam int ACC_W = 2 * ELEM_W + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-64'sd2147483648);

  logic                        busy;
  logic                        mode_a;
  logic [5:0]                  idx;
  logic                        v1;
  logic [5:0]                  idx1;
  logic                        v2;
  logic [5:0]                  idx2;
  logic signed [2*ELEM_W-1:0]  p2;
  logic                        v3;
  logic [3:0]                  idx3;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ELEM_W-1:0]    mem_e;
  logic signed [ELEM_W-1:0]    reg_e;
  logic signed [ACC_W-1:0]     rnd;
  logic [ELEM_W-1:0]           sat;

  // idx packs {r, c, k}; the memory side supplies rows of A or of B
  assign rd_row = mode_a ? idx[5:4] : idx[1:0];

  always_comb begin
    if (mode_a) begin
      mem_e = rd_data[idx1[1:0]];
      reg_e = opm[{idx1[1:0], idx1[3:2]}];
    end else begin
      mem_e = rd_data[idx1[3:2]];
      reg_e = opm[{idx1[5:4], idx1[1:0]}];
    end
  end

  always_comb begin
    rnd = (acc + HALF) >>> FRAC_BITS;
    if (rnd > SMAX) begin
      sat = SMAX[ELEM_W-1:0];
    end else if (rnd < SMIN) begin
      sat = SMIN[ELEM_W-1:0];
    end else begin
      sat = rnd[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      rsp.wr_valid <= 1'b0;
      rsp.done     <= 1'b0;
    end else begin
      if (req.start) begin
        busy   <= 1'b1;
        idx    <= 6'd0;
        mode_a <= req.mem_is_a;
      end else if (busy) begin
        idx <= idx + 6'd1;
        if (idx == 6'd63) begin
          busy <= 1'b0;
        end
      end
      v1   <= busy;
      idx1 <= idx;
      v2   <= v1;
      idx2 <= idx1;
      p2   <= mem_e * reg_e;
      v3   <= v2 && (idx2[1:0] == 2'd3);
      idx3 <= idx2[5:2];
      if (v2) begin
        if (idx2[1:0] == 2'd0) begin
          acc <= ACC_W'(p2);
        end else begin
          acc <= acc + ACC_W'(p2);
        end
      end
      rsp.wr_valid <= v3;
      rsp.wr_idx   <= idx3;
      wr_data      <= sat;
      rsp.done     <= rsp.wr_valid && (rsp.wr_idx == 4'd15);
    end
  end

endmodule

// ===== hdl/joint_chain_skinning_matrix_top.sv =====
// Load transactions produce no output. A compute transaction runs one product per chain
// level on the shared multiply-accumulate unit (issue, pipeline drain, then the CHECK and
// GNEXT control states) and then the two skin products; a walk that stops on an invalid
// index passes through one extra CHECK state. Rows then leave at one per cycle as accepted.
// Synchronous active-high reset marks every parent as root and sets joint_count to 1;
// matrix memories are not cleared.
module joint_chain_skinning_matrix_top #(
  parameter int MAX_JOINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [5:0]         joint,
  input  logic [7:0]         parent,
  input  logic [1:0]         row,
  input  logic signed [31:0] e0,
  input  logic signed [31:0] e1,
  input  logic signed [31:0] e2,
  input  logic signed [31:0] e3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         joint_out,
  output logic [1:0]         row_out,
  output logic signed [31:0] global_e0,
  output logic signed [31:0] global_e1,
  output logic signed [31:0] global_e2,
  output logic signed [31:0] global_e3,
  output logic signed [31:0] skin_e0,
  output logic signed [31:0] skin_e1,
  output logic signed [31:0] skin_e2,
  output logic signed [31:0] skin_e3,
  output logic               last_row,
  output logic               chain_error
);
  import jcsm_pkg::*;

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [7:0] MAXJ = 8'(MAX_JOINTS);

  typedef enum logic [3:0] {
    IDLE, CHECK, GWAIT, GNEXT, SKIN, S1WAIT, S2, S2WAIT, OUTP
  } state_t;

  state_t              state;
  logic [6:0]          joint_count;
  logic [5:0]          jt_reg;
  logic [7:0]          cur;
  logic [7:0]          steps;
  logic                err;
  logic [1:0]          orow;
  mat_t                g;
  mat_t                s;
  mat_t                t;
  logic [MAX_JOINTS-1:0] pvalid;

  logic                in_acc;
  logic                jt_ok;
  logic [7:0]          cnt;
  logic [JW-1:0]       jw_in;
  logic [JW-1:0]       jw_reg;
  row_t                in_row;
  row_t                local_q;
  row_t                inv_q;
  row_t                bind_q;
  logic [7:0]          par_q;
  logic [7:0]          par_eff;
  logic                local_we;
  logic                inv_we;
  logic                bind_we;
  eng_req_t            req;
  eng_rsp_t            rsp;
  mat_t                opm;
  row_t                rd_data;
  logic [1:0]          rd_row;
  logic [ELEM_W-1:0]   wr_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign in_acc    = in_valid && in_ready;
  assign jt_ok     = ({2'b00, joint} < MAXJ);
  assign jw_in     = JW'(joint);
  assign jw_reg    = JW'(jt_reg);
  assign in_row    = {e3, e2, e1, e0};
  assign cnt       = ({1'b0, joint_count} > MAXJ) ? MAXJ : {1'b0, joint_count};

  assign local_we = in_acc && (opcode == OP_LOCAL) && jt_ok;
  assign inv_we   = in_acc && (opcode == OP_INVBIND) && jt_ok;
  assign bind_we  = in_acc && (opcode == OP_BIND);

  assign par_eff = pvalid[cur[JW-1:0]] ? par_q : ROOT_MARK;

  jcsm_ram #(.WIDTH(4 * ELEM_W), .ADDR_W(JW + 2)) u_local (
    .clk(clk), .we(local_we), .waddr({jw_in, row}), .wdata(in_row),
    .raddr({cur[JW-1:0], rd_row}), .rdata(local_q)
  );

  jcsm_ram #(.WIDTH(4 * ELEM_W), .ADDR_W(JW + 2)) u_inv (
    .clk(clk), .we(inv_we), .waddr({jw_in, row}), .wdata(in_row),
    .raddr({jw_reg, rd_row}), .rdata(inv_q)
  );

  jcsm_ram #(.WIDTH(4 * ELEM_W), .ADDR_W(2)) u_bind (
    .clk(clk), .we(bind_we), .waddr(row), .wdata(in_row),
    .raddr(rd_row), .rdata(bind_q)
  );

  jcsm_ram #(.WIDTH(8), .ADDR_W(JW)) u_parent (
    .clk(clk), .we(local_we), .waddr(jw_in), .wdata(parent),
    .raddr(cur[JW-1:0]), .rdata(par_q)
  );

  always_comb begin
    req.start    = 1'b0;
    req.mem_is_a = 1'b0;
    unique case (state)
      CHECK: begin
        req.start    = (cur < cnt);
        req.mem_is_a = 1'b1;
      end
      SKIN:    req.start = ({2'b00, jt_reg} < MAXJ);
      S2:      req.start = 1'b1;
      default: req.start = 1'b0;
    endcase
  end

  always_comb begin
    opm     = (state == S2WAIT) ? s : g;
    rd_data = local_q;
    if (state == S1WAIT) begin
      rd_data = inv_q;
    end else if (state == S2WAIT) begin
      rd_data = bind_q;
    end
  end

  jcsm_matmul #(.FRAC_BITS(FRAC_BITS)) u_matmul (
    .clk(clk), .rst(rst), .req(req), .opm(opm), .rd_data(rd_data),
    .rd_row(rd_row), .rsp(rsp), .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if ((state == SKIN) && ({2'b00, jt_reg} >= MAXJ)) begin
      // no inverse bind matrix: skin collapses to zero
      t <= '0;
    end else if (rsp.wr_valid) begin
      t[rsp.wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= 7'd1;
      pvalid      <= '0;
    end else begin
      if (cfg_valid) begin
        joint_count <= cfg_data;
      end
      if (local_we) begin
        pvalid[jw_in] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_acc && (opcode == OP_COMPUTE)) begin
            jt_reg <= joint;
            cur    <= {2'b00, joint};
            steps  <= 8'd0;
            err    <= 1'b0;
            g      <= '0;
            for (int i = 0; i < 4; i++) begin
              g[i * 5] <= ELEM_W'(1) << FRAC_BITS;
            end
            state <= CHECK;
          end
        end
        CHECK: begin
          if (cur < cnt) begin
            state <= GWAIT;
          end else begin
            err   <= 1'b1;
            state <= SKIN;
          end
        end
        GWAIT: begin
          if (rsp.done) begin
            g     <= t;
            steps <= steps + 8'd1;
            state <= GNEXT;
          end
        end
        GNEXT: begin
          if (par_eff == ROOT_MARK) begin
            state <= SKIN;
          end else if (steps >= cnt) begin
            err   <= 1'b1;
            state <= SKIN;
          end else begin
            cur   <= par_eff;
            state <= CHECK;
          end
        end
        SKIN: begin
          if ({2'b00, jt_reg} < MAXJ) begin
            state <= S1WAIT;
          end else begin
            orow  <= 2'd0;
            state <= OUTP;
          end
        end
        S1WAIT: begin
          if (rsp.done) begin
            s     <= t;
            state <= S2;
          end
        end
        S2: state <= S2WAIT;
        S2WAIT: begin
          if (rsp.done) begin
            orow  <= 2'd0;
            state <= OUTP;
          end
        end
        OUTP: begin
          if (out_ready) begin
            orow <= orow + 2'd1;
            if (orow == 2'd3) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_valid   = (state == OUTP);
  assign joint_out   = jt_reg;
  assign row_out     = orow;
  assign last_row    = (orow == 2'd3);
  assign chain_error = err;
  assign global_e0   = g[{orow, 2'd0}];
  assign global_e1   = g[{orow, 2'd1}];
  assign global_e2   = g[{orow, 2'd2}];
  assign global_e3   = g[{orow, 2'd3}];
  assign skin_e0     = t[{orow, 2'd0}];
  assign skin_e1     = t[{orow, 2'd1}];
  assign skin_e2     = t[{orow, 2'd2}];
  assign skin_e3     = t[{orow, 2'd3}];

endmodule

// ===== sim/tb.sv =====
module tb;
  import jcsm_pkg::*;

  localparam int FRAC = 16;
  localparam int JMAX = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef int mat16_t[16];
  typedef int row4_t[4];

  typedef struct {
    bit [5:0] jt;
    bit [1:0] rw;
    row4_t    glob;
    row4_t    skin;
    bit       lst;
    bit       err;
  } pose_row_t;

  // Q16.16 product: exact sum of four terms, round half up, saturate
  function automatic void fx_mat_mul(input mat16_t a, input mat16_t b, output mat16_t c);
    longint p, f, hi, lo, q;
    for (int r = 0; r < 4; r++) begin
      for (int col = 0; col < 4; col++) begin
        hi = 0;
        lo = 0;
        for (int k = 0; k < 4; k++) begin
          p = longint'(a[r*4+k]) * longint'(b[k*4+col]);
          f = p >>> FRAC;
          hi += f;
          lo += p - (f <<< FRAC);
        end
        q = hi + ((lo + (longint'(1) <<< (FRAC-1))) >>> FRAC);
        if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
        if (q < -64'sh80000000) q = -64'sh80000000;
        c[r*4+col] = int'(q);
      end
    end
  endfunction

  class skin_scoreboard;
    int       loc_m[JMAX][16];
    int       inv_m[JMAX][16];
    int       bs_m[16];
    bit [7:0] par_m[JMAX];
    bit [3:0] loc_wr[JMAX];
    bit [3:0] inv_wr[JMAX];
    bit [3:0] bs_wr;
    int unsigned jcount;
    pose_row_t pending[$];
    int errors;
    int rows_seen;
    int computes;
    int chain_errs;

    function new();
      foreach (par_m[i]) begin
        par_m[i] = ROOT_MARK;
        loc_wr[i] = 0;
        inv_wr[i] = 0;
      end
      bs_wr = 0;
      jcount = 1;
    endfunction

    // walk the parent chain; returns 0 if it would touch an unloaded matrix
    function bit walk_chain(input bit [5:0] j, output mat16_t g, output bit err);
      int unsigned cnt, cur, steps;
      mat16_t lm;
      cnt = (jcount > JMAX) ? JMAX : jcount;
      foreach (g[i]) g[i] = (i % 5 == 0) ? (1 << FRAC) : 0;
      err = 0;
      cur = j;
      steps = 0;
      forever begin
        if (cur >= cnt) begin
          err = 1;
          break;
        end
        if (loc_wr[cur] != 4'hF) return 0;
        lm = loc_m[cur];
        fx_mat_mul(lm, g, g);
        steps++;
        if (par_m[cur] == ROOT_MARK) break;
        if (steps >= cnt) begin
          err = 1;
          break;
        end
        cur = par_m[cur];
      end
      return 1;
    endfunction

    function bit compute_ok(input bit [5:0] j);
      mat16_t g;
      bit err;
      if (bs_wr != 4'hF || inv_wr[j] != 4'hF) return 0;
      return walk_chain(j, g, err);
    endfunction

    function void note_item(input bit [1:0] op, input bit [5:0] j, input bit [7:0] par,
                            input bit [1:0] rw, input row4_t e);
      mat16_t g, s, im, bm;
      bit err;
      pose_row_t x;
      case (op)
        OP_BIND: begin
          for (int i = 0; i < 4; i++) bs_m[rw*4+i] = e[i];
          bs_wr[rw] = 1;
        end
        OP_LOCAL: begin
          for (int i = 0; i < 4; i++) loc_m[j][rw*4+i] = e[i];
          loc_wr[j][rw] = 1;
          par_m[j] = par;
        end
        OP_INVBIND: begin
          for (int i = 0; i < 4; i++) inv_m[j][rw*4+i] = e[i];
          inv_wr[j][rw] = 1;
        end
        default: begin
          void'(walk_chain(j, g, err));
          im = inv_m[j];
          bm = bs_m;
          fx_mat_mul(g, im, s);
          fx_mat_mul(s, bm, s);
          computes++;
          if (err) chain_errs++;
          for (int r = 0; r < 4; r++) begin
            x.jt = j;
            x.rw = 2'(r);
            for (int i = 0; i < 4; i++) begin
              x.glob[i] = g[r*4+i];
              x.skin[i] = s[r*4+i];
            end
            x.lst = (r == 3);
            x.err = err;
            pending.push_back(x);
          end
        end
      endcase
    endfunction

    function void cmp(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_row(input bit [5:0] j, input bit [1:0] r, input row4_t g,
                            input row4_t s, input bit lst, input bit err);
      pose_row_t x;
      rows_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected row, actual joint %0d row %0d", $time, j, r);
        errors++;
        return;
      end
      x = pending.pop_front();
      cmp("joint_out", x.jt, j);
      cmp("row_out", x.rw, r);
      for (int i = 0; i < 4; i++) begin
        cmp($sformatf("global_e%0d", i), x.glob[i], g[i]);
        cmp($sformatf("skin_e%0d", i), x.skin[i], s[i]);
      end
      cmp("last_row", x.lst, lst);
      cmp("chain_error", x.err, err);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst;
  logic               cfg_valid, cfg_ready;
  logic [6:0]         cfg_data;
  logic               in_valid, in_ready;
  logic [1:0]         opcode;
  logic [5:0]         joint;
  logic [7:0]         parent;
  logic [1:0]         row;
  logic signed [31:0] e0, e1, e2, e3;
  logic               out_valid, out_ready;
  logic [5:0]         joint_out;
  logic [1:0]         row_out;
  logic signed [31:0] global_e0, global_e1, global_e2, global_e3;
  logic signed [31:0] skin_e0, skin_e1, skin_e2, skin_e3;
  logic               last_row, chain_error;

  skin_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int sent;
  int cycles;

  joint_chain_skinning_matrix_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .joint(joint), .parent(parent), .row(row),
    .e0(e0), .e1(e1), .e2(e2), .e3(e3),
    .out_valid(out_valid), .out_ready(out_ready),
    .joint_out(joint_out), .row_out(row_out),
    .global_e0(global_e0), .global_e1(global_e1),
    .global_e2(global_e2), .global_e3(global_e3),
    .skin_e0(skin_e0), .skin_e1(skin_e1), .skin_e2(skin_e2), .skin_e3(skin_e3),
    .last_row(last_row), .chain_error(chain_error)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("joint_chain_skinning_matrix_top verification failed");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready)
        sb.check_row(joint_out, row_out, '{global_e0, global_e1, global_e2, global_e3},
                     '{skin_e0, skin_e1, skin_e2, skin_e3}, last_row, chain_error);
    end
  end

  function automatic int rnd_elem();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1, 2: return $urandom;
      default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  task automatic send_item(input bit [1:0] op, input bit [5:0] j, input bit [7:0] par,
                           input bit [1:0] rw, input row4_t e);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    joint <= j;
    parent <= par;
    row <= rw;
    e0 <= e[0];
    e1 <= e[1];
    e2 <= e[2];
    e3 <= e[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, j, par, rw, e);
    sent++;
  endtask

  // load all four rows of one matrix, optionally forcing extreme values
  task automatic load_matrix(input bit [1:0] op, input bit [5:0] j, input bit [7:0] par,
                             input bit extreme);
    row4_t e;
    for (int r = 0; r < 4; r++) begin
      foreach (e[i]) e[i] = rnd_elem();
      if (extreme && r == 0) e = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, -1};
      send_item(op, j, par, 2'(r), e);
    end
  endtask

  task automatic compute_joint(input bit [5:0] j);
    send_item(OP_COMPUTE, j, 8'($urandom_range(255)), 2'($urandom_range(3)),
              '{$urandom, $urandom, $urandom, $urandom});
  endtask

  // hold the sender until every pending transaction has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input bit [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.jcount = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int stop_at, cnt, len, pick;
    bit [5:0] j;
    bit [7:0] prev, par;
    row4_t e;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      cnt = (sb.jcount > JMAX) ? JMAX : sb.jcount;
      pick = $urandom_range(9);
      if (pick <= 5) begin
        // chain, root first: each joint points at the previous one, or at a random parent one time in ten
        len = $urandom_range(1, 3);
        prev = ROOT_MARK;
        for (int k = 0; k < len; k++) begin
          j = (cnt > 0 && $urandom_range(7) != 0) ? 6'($urandom_range(0, cnt-1))
                                                  : 6'($urandom_range(0, 63));
          par = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255)) : prev;
          load_matrix(OP_LOCAL, j, par, $urandom_range(15) == 0);
          prev = j;
        end
        if (sb.inv_wr[j] != 4'hF || $urandom_range(1))
          load_matrix(OP_INVBIND, j, 8'($urandom_range(255)), 1'b0);
        if (sb.compute_ok(j)) compute_joint(j);
      end else if (pick <= 7) begin
        foreach (e[i]) e[i] = rnd_elem();
        send_item(2'($urandom_range(2)), 6'($urandom_range(63)), 8'($urandom_range(255)),
                  2'($urandom_range(3)), e);
      end else begin
        j = 6'($urandom_range(63));
        if (sb.compute_ok(j)) compute_joint(j);
      end
    end
  endtask

  initial begin
    row4_t e;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_LOCAL;
    joint <= '0;
    parent <= '0;
    row <= '0;
    e0 <= '0;
    e1 <= '0;
    e2 <= '0;
    e3 <= '0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single root joint, then chain bounds
    load_matrix(OP_BIND, 6'd63, 8'd0, 1'b0);
    load_matrix(OP_LOCAL, 6'd0, ROOT_MARK, 1'b1);
    load_matrix(OP_INVBIND, 6'd0, 8'd0, 1'b1);
    compute_joint(6'd0);
    write_count(7'd0);
    compute_joint(6'd0);
    write_count(7'd2);
    load_matrix(OP_LOCAL, 6'd1, 8'd0, 1'b0);
    load_matrix(OP_INVBIND, 6'd1, 8'd255, 1'b0);
    compute_joint(6'd1);
    // make joint 0 point back at joint 1 so the walk runs past the count
    e = '{1 << FRAC, 0, 0, 0};
    send_item(OP_LOCAL, 6'd0, 8'd1, 2'd0, e);
    compute_joint(6'd1);

    write_count(7'd127);
    idle_pct = 0;
    stall_pct = 0;
    random_phase(16);
    write_count(7'd64);
    idle_pct = 66;
    random_phase(16);
    write_count(7'($urandom_range(2, 63)));
    idle_pct = 0;
    stall_pct = 66;
    random_phase(16);
    write_count(7'd1);
    idle_pct = 13;
    stall_pct = 13;
    random_phase(8);
    write_count(7'd5);
    random_phase(8);

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d transactions over joint counts 0..127, %0d computes (%0d chain errors)",
             sent, sb.computes, sb.chain_errs);
    $display("Checked %0d output rows, %0d mismatches", sb.rows_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("joint_chain_skinning_matrix_top verification clean");
    end else begin
      $display("joint_chain_skinning_matrix_top verification failed");
    end
    $finish;
  end

endmodule
